FILE: src/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding window maximum package
// shared widths and constants of the sliding window maximum block
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned MAX_WINDOW  = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_WINDOW);
  localparam int unsigned SIZE_W      = $clog2(MAX_WINDOW + 1);

  localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = SIZE_W'(16);

endpackage

FILE: src/sliding_window_maximum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding window maximum
// running maximum over the last window_size samples, kept in a ring store
// ----------------------------------------------------------------------------
// an item passes check, then emit, which loads the output register, unless
// the window is still short of full; a rescan of the k samples, k being the
// effective size (1..64), comes between when the maximum leaves the window;
// one item at a time, taken in idle; a stalled result keeps the block in emit
// reset: control state cleared, window_size back to 16, window empty;
// store contents are undefined until written
module sliding_window_maximum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swm_pkg::SIZE_W-1:0]     window_size_i,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                           start_of_sequence_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [swm_pkg::SAMPLE_BITS-1:0] window_max_o
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item or a configuration write
    ST_CHECK,  // departing sample available from the store
    ST_SCAN,   // rescanning the window through the read port
    ST_EMIT    // handing the maximum to the output register
  } state_e;

  // window store: one write and one read port, registered read data
  logic [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_raddr;

  state_e                 state_d, state_q;
  logic [SIZE_W-1:0]      win_size_d, win_size_q;
  logic [ADDR_W-1:0]      wr_ptr_d, wr_ptr_q;       // ring position of next sample
  logic [ADDR_W-1:0]      cur_ptr_d, cur_ptr_q;     // ring position of item in flight
  logic [SIZE_W-1:0]      fill_d, fill_q;
  logic [SAMPLE_BITS-1:0] cur_max_d, cur_max_q;
  logic [SAMPLE_BITS-1:0] sample_d, sample_q;
  logic [SIZE_W-1:0]      scan_idx_d, scan_idx_q;
  logic                   scan_pend_d, scan_pend_q;  // read data of the scan due
  logic                   out_valid_d, out_valid_q;
  logic [SAMPLE_BITS-1:0] out_data_d, out_data_q;

  // effective window length: zero reads as one, large values saturate
  logic [SIZE_W-1:0]      win_len;
  // position and fill seen by a new item, after an optional start of sequence
  logic [ADDR_W-1:0]      ptr_base;
  logic [ADDR_W-1:0]      ptr_eff;
  logic [ADDR_W-1:0]      ptr_next;
  logic                   in_fire;
  logic                   cfg_fire;
  logic                   out_free;

  always_comb begin
    if (win_size_q == '0) begin
      win_len = SIZE_W'(1);
    end else if (win_size_q > SIZE_W'(MAX_WINDOW)) begin
      win_len = SIZE_W'(MAX_WINDOW);
    end else begin
      win_len = win_size_q;
    end
  end

  assign ptr_base = start_of_sequence_i ? '0 : wr_ptr_q;
  assign ptr_eff  = ({1'b0, ptr_base} >= win_len) ? '0 : ptr_base;
  assign ptr_next = (({1'b0, ptr_eff} + SIZE_W'(1)) >= win_len) ? '0 : ptr_eff + ADDR_W'(1);

  // a configuration write takes priority over a waiting item
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // the read port serves the departing sample at accept and the rescan after
  assign mem_raddr = (state_q == ST_SCAN) ? scan_idx_q[ADDR_W-1:0] : ptr_eff;
  assign mem_we    = (state_q == ST_CHECK);

  always_comb begin
    state_d     = state_q;
    win_size_d  = win_size_q;
    wr_ptr_d    = wr_ptr_q;
    cur_ptr_d   = cur_ptr_q;
    fill_d      = fill_q;
    cur_max_d   = cur_max_q;
    sample_d    = sample_q;
    scan_idx_d  = scan_idx_q;
    scan_pend_d = 1'b0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          // new size empties the window
          win_size_d = window_size_i;
          fill_d     = '0;
          wr_ptr_d   = '0;
          cur_max_d  = '0;
        end else if (in_fire) begin
          sample_d  = sample_i;
          cur_ptr_d = ptr_eff;
          wr_ptr_d  = ptr_next;
          if (start_of_sequence_i) begin
            fill_d    = '0;
            cur_max_d = '0;
          end
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (fill_q < win_len) begin
          // window still filling
          fill_d = fill_q + SIZE_W'(1);
          if (sample_q > cur_max_q) begin
            cur_max_d = sample_q;
          end
          state_d = ((fill_q + SIZE_W'(1)) == win_len) ? ST_EMIT : ST_IDLE;
        end else if (cur_max_q < sample_q) begin
          cur_max_d = sample_q;
          state_d   = ST_EMIT;
        end else if (cur_max_q != rd_data_q) begin
          // maximum still inside the window
          state_d = ST_EMIT;
        end else begin
          // maximum leaves the window: rescan from zero
          cur_max_d  = '0;
          scan_idx_d = '0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (scan_pend_q && (rd_data_q > cur_max_q)) begin
          cur_max_d = rd_data_q;
        end
        if (scan_idx_q < win_len) begin
          scan_idx_d  = scan_idx_q + SIZE_W'(1);
          scan_pend_d = 1'b1;
        end else if (!scan_pend_q) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = cur_max_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_size_q  <= WINDOW_SIZE_RESET;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      cur_max_q   <= '0;
      scan_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_size_q  <= win_size_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      cur_max_q   <= cur_max_d;
      scan_pend_q <= scan_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_ptr_q  <= cur_ptr_d;
    sample_q   <= sample_d;
    scan_idx_q <= scan_idx_d;
    out_data_q <= out_data_d;
  end

  // window store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[cur_ptr_q] <= sample_q;
    end
    rd_data_q <= store_mem[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_data_q;

endmodule

FILE: src/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding window maximum checker
// port level checks of the sliding window maximum block
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [swm_pkg::SAMPLE_BITS-1:0] window_max_o
);
  import swm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_max_o))
    else $error("result dropped or changed while stalled");

  // one item at a time: an accepted item closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // a new result only follows processing, never straight from idle
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without an item in flight");

  // configuration is only taken while no item is in flight
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !(in_valid_i && in_ready_o))
    else $error("configuration write collided with an item");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding window maximum testbench
// drives samples and window size writes into the block, predicts every
// window maximum in a scoreboard and checks results in order of arrival
// ----------------------------------------------------------------------------
module tb;
  import swm_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1800;
  // room for the worst rescan item, k up to MAX_WINDOW, plus a margin
  localparam int unsigned DRAIN_CYCLES   = MAX_WINDOW + 16;
  localparam int unsigned HOLD_OFF_LEN   = 400;

  // flavour of sample content within one burst
  typedef enum int unsigned {
    STYLE_WIDE,
    STYLE_NARROW,
    STYLE_FALLING,
    STYLE_EDGES
  } sample_style_e;

  // sixteen corner patterns for the window at its reset size
  localparam logic [SAMPLE_BITS-1:0] EDGE_SAMPLES [16] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
    32'h0000_FFFF, 32'hFFFF_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
    32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [SIZE_W-1:0]      window_size_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] sample_i;
  logic                   start_of_sequence_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [SAMPLE_BITS-1:0] window_max_o;

  // keeps its own copy of the window and the expected maxima, oldest first
  class swm_scoreboard;
    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] run_max;
    int unsigned            fill;
    int unsigned            ptr;
    logic [SIZE_W-1:0]      size_reg;
    logic [SAMPLE_BITS-1:0] expected_max [$];
    int unsigned            errors;
    int unsigned            checked;
    int unsigned            rescans;
    int unsigned            samples;

    function new();
      foreach (ring[i]) ring[i] = '0;
      size_reg = WINDOW_SIZE_RESET;
      errors   = 0;
      checked  = 0;
      rescans  = 0;
      samples  = 0;
      restart();
    endfunction

    function void restart();
      run_max = '0;
      fill    = 0;
      ptr     = 0;
    endfunction

    function void set_window(logic [SIZE_W-1:0] v);
      size_reg = v;
      restart();
    endfunction

    // zero acts as one, anything above the store depth saturates
    function int unsigned span();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_WINDOW) return MAX_WINDOW;
      return 32'(size_reg);
    endfunction

    function int unsigned pending();
      return expected_max.size();
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s, logic sos);
      int unsigned            k;
      int unsigned            slot;
      logic [SAMPLE_BITS-1:0] leaving;
      k = span();
      samples++;
      if (sos) restart();
      if (ptr >= k) ptr = 0;
      slot = ptr;
      ptr  = (slot + 1 >= k) ? 0 : slot + 1;
      if (fill < k) begin
        ring[slot] = s;
        if (s > run_max) run_max = s;
        fill++;
        if (fill == k) expected_max.insert(expected_max.size(), run_max);
        return;
      end
      leaving    = ring[slot];
      ring[slot] = s;
      if (s > run_max) begin
        run_max = s;
      end else if (run_max == leaving) begin
        // the maximum just left, so look through the whole window again
        rescans++;
        run_max = '0;
        for (int j = 0; j < k; j++) begin
          if (ring[j] > run_max) run_max = ring[j];
        end
      end
      expected_max.insert(expected_max.size(), run_max);
    endfunction

    function void check_max(logic [SAMPLE_BITS-1:0] got);
      logic [SAMPLE_BITS-1:0] want;
      if (expected_max.size() == 0) begin
        errors++;
        $display("%0t: window_max expected none actual 0x%08h", $time, got);
        return;
      end
      want = expected_max[0];
      expected_max.delete(0);
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: window_max expected 0x%08h actual 0x%08h", $time, want, got);
      end
    endfunction
  endclass

  swm_scoreboard          sb = new();
  logic                   hold_off_req;
  logic                   sink_stalls;
  logic [SAMPLE_BITS-1:0] ramp;
  int unsigned            cfg_writes;

  sliding_window_maximum u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .window_size_i       (window_size_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sample_i            (sample_i),
    .start_of_sequence_i (start_of_sequence_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .window_max_o        (window_max_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous ceiling, well above the slowest legal run
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d results still awaited", $time, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // every accepted result goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_max(window_max_o);
  end

  // result side: ready and stall runs of random length, plus one long hold-off
  // counted here while the sender keeps offering items
  initial begin : result_sink
    int unsigned run_left;
    int unsigned hold_left;
    logic        sink_on;
    logic        hold_taken;
    out_ready_i = 1'b0;
    run_left    = 0;
    hold_left   = 0;
    sink_on     = 1'b0;
    hold_taken  = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          sink_on = !sink_on || !sink_stalls;
          run_left = sink_on ? $urandom_range(1, 20) : $urandom_range(1, 10);
        end
        run_left--;
        out_ready_i <= sink_on;
      end
    end
  end

  // payload changes only after acceptance, valid stays up between items
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic sos);
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    sample_i            <= s;
    start_of_sequence_i <= sos;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s, sos);
  endtask

  task automatic pause(input int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // wait for every result, then for a filling item still in flight
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [SIZE_W-1:0] v);
    settle();
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    window_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_window(v);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] next_sample(input sample_style_e style);
    case (style)
      STYLE_WIDE:   return $urandom;
      STYLE_NARROW: return $urandom_range(0, 7);
      STYLE_FALLING: begin
        // falling values push the maximum out of the window every step
        ramp = ramp - $urandom_range(0, 3);
        return ramp;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 1;
          default: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        endcase
      end
    endcase
  endfunction

  // mostly small windows, the odd large or out-of-range setting
  function automatic logic [SIZE_W-1:0] pick_window();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return SIZE_W'($urandom_range(1, 8));
    if (r < 85) return SIZE_W'($urandom_range(9, 32));
    if (r < 92) return SIZE_W'($urandom_range(33, 64));
    if (r < 95) return SIZE_W'(MAX_WINDOW);
    if (r < 97) return '0;
    return SIZE_W'($urandom_range(MAX_WINDOW + 1, 127));
  endfunction

  // bursts of one content style, restarts rare enough that windows fill
  task automatic run_phase(input int unsigned n_items, input logic gaps);
    int unsigned   burst;
    int unsigned   restart_odds;
    sample_style_e style;
    restart_odds = 4 * sb.span() + 20;
    while (n_items > 0) begin
      burst = $urandom_range(1, 24);
      style = sample_style_e'($urandom_range(0, 3));
      ramp  = $urandom;
      while (burst > 0 && n_items > 0) begin
        send_sample(next_sample(style), $urandom_range(0, restart_odds) == 0);
        burst--;
        n_items--;
      end
      if (gaps) pause($urandom_range(0, 8));
    end
  endtask

  initial begin
    int unsigned       random_sent;
    int unsigned       n;
    int unsigned       phase;
    logic [SIZE_W-1:0] size;

    rst_ni              = 1'b0;
    cfg_valid_i         = 1'b0;
    window_size_i       = '0;
    in_valid_i          = 1'b0;
    sample_i            = '0;
    start_of_sequence_i = 1'b0;
    hold_off_req        = 1'b0;
    sink_stalls         = 1'b1;
    ramp                = '0;
    cfg_writes          = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset window of sixteen, filled with corner patterns: one result
    foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i], i == 0);

    // size zero behaves as a one-sample window, every item answers
    write_window(0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0007, 1'b0);

    // falling run in a window of three forces a rescan on each step once full,
    // then a new sequence goes back to filling
    write_window(3);
    send_sample(32'd9, 1'b0);
    send_sample(32'd8, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(32'd6, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b1);

    // back-pressure: results blocked long enough that the input stalls
    write_window(4);
    sink_stalls = 1'b0;
    repeat (8) send_sample($urandom, 1'b0);
    hold_off_req = 1'b1;
    repeat (80) send_sample($urandom, 1'b0);

    // random phases, the extremes of the window setting first
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0:       size = 1;
        1:       size = SIZE_W'(MAX_WINDOW);
        2:       size = 127;
        3:       size = 0;
        default: size = pick_window();
      endcase
      write_window(size);
      sink_stalls = $urandom_range(0, 3) != 0;
      n = $urandom_range(80, 220);
      run_phase(n, $urandom_range(0, 3) != 0);
      random_sent += n;
      phase++;
    end

    settle();
    $display("%0d samples over %0d window settings, %0d maxima checked, %0d rescans",
             sb.samples, cfg_writes, sb.checked, sb.rescans);
    $display("window sizes from zero to saturated, long result hold-off included");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/swm_pkg.sv
src/sliding_window_maximum.sv
src/swm_checker.sv
bench/tb.sv
